// File: design/cfss_pkg.sv
// Shared types and constants for the full-scale contrast stretch unit.
package cfss_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned DIV_STEPS = PIX_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [PIX_W-1:0] FULL_SCALE   = 8'd255;
  localparam logic [PIX_W-1:0] ZERO_LEVEL   = 8'd0;
  localparam logic [PIX_W-1:0] DARK_RESET   = 8'd255;
  localparam logic [PIX_W-1:0] BRIGHT_RESET = 8'd0;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_MAP     = 1'b1;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic measure;
    logic load;
    logic step;
    logic out_load;
  } cmd_t;

endpackage

// File: design/cfss_ctrl.sv
// Controller state machine that sequences measure updates, the divider and the output register.
module cfss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output cfss_pkg::cmd_t cmd
);
  import cfss_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_xfer;
  logic             out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_op == OP_MAP) begin
          state_nxt = S_DIV;
          count_nxt = '0;
        end
      end
      S_DIV: begin
        count_nxt = count_r + 1'b1;
        if (count_r == LAST_STEP) begin
          state_nxt = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        count_nxt = '0;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.measure = in_xfer && in_op == OP_MEASURE;
        cmd.load    = in_xfer && in_op == OP_MAP;
      end
      S_DIV: begin
        cmd.step     = 1'b1;
        cmd.out_load = (count_r == LAST_STEP) && out_free;
      end
      S_HOLD: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("Output register loaded while a result still waits.");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> count_r == '0)
    else $error("Step counter not at zero in idle.");

  a_hold_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HOLD |-> out_valid_r)
    else $error("Holding a result while the output register is empty.");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && count_r == LAST_STEP && out_free) |=>
      (state_r == S_IDLE && out_valid_r))
    else $error("Finished division did not reach the output register.");

endmodule

// File: design/cfss_dpath.sv
// Datapath with the end-point registers, a serial restoring divider and the output register.
module cfss_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfss_pkg::cmd_t                cmd,
  input  logic                          in_first_pixel,
  input  logic [cfss_pkg::PIX_W-1:0]    in_pixel_in,
  output logic [cfss_pkg::PIX_W-1:0]    out_pixel_out
);
  import cfss_pkg::*;

  logic [PIX_W-1:0]   lo_r, lo_nxt;
  logic [PIX_W-1:0]   hi_r, hi_nxt;
  logic [PIX_W-1:0]   rem_r, rem_nxt;
  logic [PIX_W-1:0]   nlo_r, nlo_nxt;
  logic [PIX_W-1:0]   span_r, span_nxt;
  logic [PIX_W-1:0]   q_r, q_nxt;
  logic               special_r, special_nxt;
  logic [PIX_W-1:0]   spec_val_r, spec_val_nxt;
  logic [PIX_W-1:0]   out_r, out_nxt;
  logic [PIX_W-1:0]   diff;
  logic [2*PIX_W-1:0] num;
  logic [PIX_W:0]     trial;
  logic [PIX_W:0]     trial_sub;
  logic               ge;

  assign diff      = in_pixel_in - lo_r;
  assign num       = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
  assign trial     = {rem_r, nlo_r[PIX_W-1]};
  assign trial_sub = trial - {1'b0, span_r};
  assign ge        = (trial >= {1'b0, span_r});

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.measure) begin
      if (in_first_pixel) begin
        lo_nxt = in_pixel_in;
        hi_nxt = in_pixel_in;
      end else begin
        if (in_pixel_in < lo_r) begin
          lo_nxt = in_pixel_in;
        end
        if (in_pixel_in > hi_r) begin
          hi_nxt = in_pixel_in;
        end
      end
    end
  end

  always_comb begin
    rem_nxt      = rem_r;
    nlo_nxt      = nlo_r;
    span_nxt     = span_r;
    q_nxt        = q_r;
    special_nxt  = special_r;
    spec_val_nxt = spec_val_r;
    if (cmd.load) begin
      rem_nxt  = num[2*PIX_W-1:PIX_W];
      nlo_nxt  = num[PIX_W-1:0];
      span_nxt = hi_r - lo_r;
      if (hi_r <= lo_r || in_pixel_in <= lo_r) begin
        special_nxt  = 1'b1;
        spec_val_nxt = ZERO_LEVEL;
      end else if (in_pixel_in >= hi_r) begin
        special_nxt  = 1'b1;
        spec_val_nxt = FULL_SCALE;
      end else begin
        special_nxt  = 1'b0;
        spec_val_nxt = ZERO_LEVEL;
      end
    end else if (cmd.step) begin
      rem_nxt = ge ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];
      nlo_nxt = {nlo_r[PIX_W-2:0], 1'b0};
      q_nxt   = {q_r[PIX_W-2:0], ge};
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.out_load) begin
      if (special_r) begin
        out_nxt = spec_val_r;
      end else if (cmd.step) begin
        out_nxt = q_nxt;
      end else begin
        out_nxt = q_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= DARK_RESET;
      hi_r <= BRIGHT_RESET;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    nlo_r      <= nlo_nxt;
    span_r     <= span_nxt;
    q_r        <= q_nxt;
    special_r  <= special_nxt;
    spec_val_r <= spec_val_nxt;
    out_r      <= out_nxt;
  end

  assign out_pixel_out = out_r;

endmodule

// File: design/contrast_full_scale_stretch_unit.sv
// Top level of the min-max contrast stretch unit for 8-bit grey pixels.
// A measure pixel is taken and yields no result; the next transfer can follow at once.
// A map pixel is loaded, then passes through 8 steps of the serial divider, one quotient bit each.
// The last divider step writes the output register, so a new pixel is taken while a result waits.
// If the output register is still full at that point, the result holds until it is taken.
// Synchronous active-low reset sets the darkest level to 255, the brightest to 0, and empties the output.
module contrast_full_scale_stretch_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic                       in_first_pixel,
  input  logic [cfss_pkg::PIX_W-1:0] in_pixel_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cfss_pkg::PIX_W-1:0] out_pixel_out
);
  import cfss_pkg::*;

  cmd_t cmd;

  cfss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cfss_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_first_pixel (in_first_pixel),
    .in_pixel_in    (in_pixel_in),
    .out_pixel_out  (out_pixel_out)
  );

endmodule
